/* rtl/pcrc_pkg.sv */
// Package: shared constants, types and the byte-wise CRC-32 fold for the page CRC unit.
`default_nettype none

package pcrc_pkg;

    // Page size in bytes; position counter width follows from it.
    localparam int PAGE_BYTES = 4096;
    localparam int POS_W      = $clog2(PAGE_BYTES);
    localparam int OFF_W      = 12;
    localparam int CMP_W      = (POS_W > OFF_W) ? POS_W : OFF_W;
    localparam int FIELD_BYTES = 4;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAGE_MODE    = 1'b0,
        REG_FIELD_OFFSET = 1'b1
    } cfg_reg_t;

    typedef logic [POS_W-1:0] pos_t;

    // One byte folded into a reflected CRC-32, eight shift steps.
    function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] x;
        x = {24'd0, crc[7:0] ^ b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return (crc >> 8) ^ x;
    endfunction

endpackage

`default_nettype wire

/* rtl/pcrc_if.sv */
// Interfaces: byte input channel, checksum output channel and configuration write channel.
`default_nettype none

interface pcrc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface pcrc_sum_if;
    logic        valid;
    logic        ready;
    logic [31:0] checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

interface pcrc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pcrc_pkg::CFG_IDX_W-1:0]  index;
    logic [pcrc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/page_crc32_masked_field_unit.sv */
// Top level: byte-serial reflected CRC-32 with plain-stream and fixed-page modes.
//
// One byte word per cycle, sustained, unless a byte that closes a message is
// held behind a waiting checksum (see below). An accepted byte sits in the
// input stage and is folded into the running CRC as it leaves that stage.
// When it closes a message, its checksum goes to the output register then
// and shows on sum_ch. The combinational byte fold (eight shift/xor steps of
// the 0xEDB88320 polynomial) sets the rate. In plain mode (page_mode = 0) a
// checksum word is produced on the byte flagged last_byte. In page mode the
// unit counts bytes in a page of pcrc_pkg::PAGE_BYTES, folds the four bytes
// starting at field_offset as zeros, and produces the checksum after the
// final byte of the page, ignoring last_byte. After each checksum the CRC
// returns to all ones and the position to zero. Config writes (cfg_ch, always
// ready) are meant for idle periods; they never touch the running CRC or
// position. A finished checksum waiting on sum_ch does not stop the input by
// itself: bytes keep flowing through the input stage until the next byte that
// closes a message reaches it. That byte holds the input until the waiting
// checksum is taken.
`default_nettype none

module page_crc32_masked_field_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    pcrc_byte_if.sink       data_ch,
    pcrc_sum_if.source      sum_ch,
    pcrc_cfg_if.sink        cfg_ch
);

    // Configuration registers
    logic                      page_mode_reg;
    logic [pcrc_pkg::OFF_W-1:0] field_offset_reg;

    // Input-side position tracking
    pcrc_pkg::pos_t pos_reg, pos_next;

    // Input stage
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_emit_reg;

    // CRC and output stage
    logic [31:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] checksum_reg;

    logic        data_acc;
    logic        s1_adv;
    logic        in_mask;
    logic        in_emit;
    logic        page_end;
    logic [pcrc_pkg::CMP_W-1:0] pos_ext, off_ext, pos_diff;
    logic [31:0] crc_fold;

    // ---------------- configuration ----------------
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            page_mode_reg    <= 1'b0;
            field_offset_reg <= '0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (pcrc_pkg::cfg_reg_t'(cfg_ch.index))
                pcrc_pkg::REG_PAGE_MODE:    page_mode_reg    <= cfg_ch.data[0];
                pcrc_pkg::REG_FIELD_OFFSET: field_offset_reg <= cfg_ch.data[pcrc_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshakes ----------------
    // Stage 1 moves on unless it carries a result and the output is blocked.
    assign s1_adv        = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || sum_ch.ready);
    assign data_ch.ready = !s1_valid_reg || s1_adv;
    assign data_acc      = data_ch.valid && data_ch.ready;

    // ---------------- position / mask at input ----------------
    assign pos_ext  = pcrc_pkg::CMP_W'(pos_reg);
    assign off_ext  = pcrc_pkg::CMP_W'(field_offset_reg);
    assign pos_diff = pos_ext - off_ext;
    assign page_end = (pos_reg >= pcrc_pkg::POS_W'(pcrc_pkg::PAGE_BYTES - 1));

    always_comb
    begin
        in_mask  = 1'b0;
        in_emit  = data_ch.last_byte;
        pos_next = pos_reg;
        if (!page_mode_reg)
        begin
            if (data_acc)
                pos_next = '0;
        end
        else
        begin
            // Field bytes past the page end never arrive, so no clipping needed.
            in_mask = (pos_ext >= off_ext) &&
                      (pos_diff < pcrc_pkg::CMP_W'(pcrc_pkg::FIELD_BYTES));
            in_emit = page_end;
            if (data_acc)
                pos_next = page_end ? '0 : pos_reg + pcrc_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    // ---------------- input stage ----------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (data_acc)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk) begin
        if (data_acc)
        begin
            s1_byte_reg <= in_mask ? 8'h00 : data_ch.byte_value;
            s1_emit_reg <= in_emit;
        end
    end

    // ---------------- CRC fold and output register ----------------
    assign crc_fold = pcrc_pkg::fold_byte(crc_reg, s1_byte_reg);

    always_comb
    begin
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && sum_ch.ready)
            out_valid_next = 1'b0;
        if (s1_adv)
        begin
            crc_next = s1_emit_reg ? pcrc_pkg::CRC_INIT : crc_fold;
            if (s1_emit_reg)
                out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            crc_reg       <= pcrc_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_adv && s1_emit_reg)
            checksum_reg <= ~crc_fold;
    end

    assign sum_ch.valid    = out_valid_reg;
    assign sum_ch.checksum = checksum_reg;

    // ---------------- assertions ----------------
    // CRC restarts from all ones after a word closes a message.
    a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_emit_reg) |=> (crc_reg == pcrc_pkg::CRC_INIT))
        else $error("CRC not preset after checksum");

    // Plain-mode bytes keep the page position at zero.
    a_plain_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (data_acc && !page_mode_reg) |=> (pos_reg == '0))
        else $error("position moved in plain mode");

    // A blocked result in the input stage must stall the input.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit_reg && out_valid_reg && !sum_ch.ready) |-> !data_ch.ready)
        else $error("input accepted over a blocked result");

    // Position never leaves the page.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        data_acc |=> (pos_reg <= pcrc_pkg::POS_W'(pcrc_pkg::PAGE_BYTES - 1)))
        else $error("position beyond page end");

endmodule

`default_nettype wire
